### src/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared widths, codes and types of the huffman code bit packer
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int unsigned SymW       = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned MaxLen     = (MaxCodeLen < WordW) ? MaxCodeLen : WordW;
  localparam int unsigned EntryW     = LenW + WordW;
  localparam int unsigned AccW       = WordW + 7;
  localparam int unsigned MaxBytes   = 4;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  typedef logic [1:0] mode_t;
  localparam mode_t ModeLoad   = 2'd0;
  localparam mode_t ModeEncode = 2'd1;
  localparam mode_t ModeFlush  = 2'd2;

  typedef struct packed {
    logic             valid;
    mode_t            mode;
    logic             entry_ok;
  } s1_ctrl_t;

endpackage

`default_nettype wire

### src/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// generic single-port-write, one-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// code table lookup and msb-first bit packing into bytes
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                        | tuser    | tlast
//  in_     | in  | symbol[7:0] code_word[39:8] code_length[45:40]| mode     | -
//  out_    | out | out_byte[7:0] pad_bits[10:8]                 | has_byte | last
//
//  one word per cycle unless stalled; the table ram read is registered and
//  packing is done in the stage after it against the pending bit register.
//  an encode word yielding n bytes holds the output queue until all n are taken.
//  input stalls while the packing stage holds result words that cannot
//  enter the output queue. reset clears the 256 entry valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // symbol, code_word, code_length, zero fill
  input  wire logic [hcbp_pkg::InDataW-1:0]        in_tdata,
  // mode
  input  wire logic [1:0]                          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // out_byte, pad_bits, zero fill
  output logic      [hcbp_pkg::OutDataW-1:0]       out_tdata,
  // has_byte
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  import hcbp_pkg::*;

  logic [SymW-1:0]  in_sym;
  logic [WordW-1:0] in_word;
  logic [LenW-1:0]  in_len;
  logic [LenW-1:0]  sat_len;
  logic             in_acc;

  assign in_sym  = in_tdata[SymW-1:0];
  assign in_word = in_tdata[SymW+WordW-1:SymW];
  assign in_len  = in_tdata[SymW+WordW+LenW-1:SymW+WordW];
  assign sat_len = (in_len > LenW'(MaxLen)) ? LenW'(MaxLen) : in_len;
  assign in_acc  = in_tvalid && in_tready;

  logic                  wr_en;
  logic [EntryW-1:0]     rd_data;
  logic [TableDepth-1:0] valid_r;
  logic [TableDepth-1:0] valid_nxt;

  assign wr_en = in_acc && (in_tuser == ModeLoad);

  hcbp_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_sym),
    .wdata ({sat_len, in_word}),
    .re    (in_acc),
    .raddr (in_sym),
    .rdata (rd_data)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[in_sym] = 1'b1;
    end
  end

  s1_ctrl_t s1_r;
  s1_ctrl_t s1_nxt;

  logic [6:0] pend_r;
  logic [6:0] pend_nxt;
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;

  logic [LenW-1:0]  len;
  logic [AccW-1:0]  code;
  logic [AccW-1:0]  acc;
  logic [LenW-1:0]  total;
  logic [AccW:0]    aligned;
  logic [2:0]       nbytes;
  logic [7:0]       enc_bytes [MaxBytes];
  logic [7:0]       flush_byte;
  logic [2:0]       flush_pad;

  always_comb begin
    len   = s1_r.entry_ok ? rd_data[EntryW-1:WordW] : '0;
    code  = AccW'(rd_data[WordW-1:0]) & ((AccW'(1) << len) - AccW'(1));
    acc   = (AccW'(pend_r & ((7'd1 << cnt_r) - 7'd1)) << len) | code;
    total = LenW'(cnt_r) + len;
    aligned = {1'b0, acc} << (LenW'(AccW + 1) - total);
    nbytes = total[5:3];
    for (int k = 0; k < MaxBytes; k++) begin
      enc_bytes[k] = aligned[AccW-8*k -: 8];
    end
    flush_byte = 8'(pend_r) << (4'd8 - {1'b0, cnt_r});
    flush_pad  = 3'(4'd8 - {1'b0, cnt_r});
  end

  logic [7:0] ob_byte_r [MaxBytes];
  logic [7:0] ob_byte_nxt [MaxBytes];
  logic [2:0] ob_cnt_r;
  logic [2:0] ob_cnt_nxt;
  logic [1:0] ob_pos_r;
  logic [1:0] ob_pos_nxt;
  logic       ob_has_r;
  logic       ob_has_nxt;
  logic [2:0] ob_pad_r;
  logic [2:0] ob_pad_nxt;

  logic ob_pop;
  logic buf_ok;
  logic s1_emits;
  logic s1_adv;
  logic s1_fire;

  assign ob_pop = out_tvalid && out_tready;
  assign buf_ok = (ob_cnt_r == 3'd0) || ((ob_cnt_r == 3'd1) && out_tready);

  always_comb begin
    unique case (s1_r.mode)
      ModeEncode: s1_emits = (nbytes != 3'd0);
      ModeFlush:  s1_emits = 1'b1;
      default:    s1_emits = 1'b0;
    endcase
  end

  assign s1_adv    = !s1_r.valid || !s1_emits || buf_ok;
  assign s1_fire   = s1_r.valid && s1_adv;
  assign in_tready = s1_adv;

  always_comb begin
    s1_nxt = s1_r;
    if (s1_adv) begin
      s1_nxt.valid    = in_tvalid;
      s1_nxt.mode     = in_tuser;
      s1_nxt.entry_ok = valid_r[in_sym];
    end
  end

  always_comb begin
    pend_nxt    = pend_r;
    cnt_nxt     = cnt_r;
    ob_byte_nxt = ob_byte_r;
    ob_cnt_nxt  = ob_cnt_r;
    ob_pos_nxt  = ob_pos_r;
    ob_has_nxt  = ob_has_r;
    ob_pad_nxt  = ob_pad_r;
    if (ob_pop) begin
      ob_cnt_nxt = ob_cnt_r - 3'd1;
      ob_pos_nxt = ob_pos_r + 2'd1;
    end
    if (s1_fire) begin
      unique case (s1_r.mode)
        ModeEncode: begin
          pend_nxt = acc[6:0] & ((7'd1 << total[2:0]) - 7'd1);
          cnt_nxt  = total[2:0];
          if (nbytes != 3'd0) begin
            ob_byte_nxt = enc_bytes;
            ob_cnt_nxt  = nbytes;
            ob_pos_nxt  = 2'd0;
            ob_has_nxt  = 1'b1;
            ob_pad_nxt  = 3'd0;
          end
        end
        ModeFlush: begin
          pend_nxt   = '0;
          cnt_nxt    = '0;
          ob_cnt_nxt = 3'd1;
          ob_pos_nxt = 2'd0;
          if (cnt_r == 3'd0) begin
            ob_byte_nxt[0] = 8'd0;
            ob_has_nxt     = 1'b0;
            ob_pad_nxt     = 3'd0;
          end else begin
            ob_byte_nxt[0] = flush_byte;
            ob_has_nxt     = 1'b1;
            ob_pad_nxt     = flush_pad;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      s1_r     <= '0;
      pend_r   <= '0;
      cnt_r    <= '0;
      ob_cnt_r <= '0;
      ob_pos_r <= '0;
    end else begin
      valid_r  <= valid_nxt;
      s1_r     <= s1_nxt;
      pend_r   <= pend_nxt;
      cnt_r    <= cnt_nxt;
      ob_cnt_r <= ob_cnt_nxt;
      ob_pos_r <= ob_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_byte_r <= ob_byte_nxt;
    ob_has_r  <= ob_has_nxt;
    ob_pad_r  <= ob_pad_nxt;
  end

  assign out_tvalid = (ob_cnt_r != 3'd0);
  assign out_tdata  = {5'd0, ob_pad_r, ob_byte_r[ob_pos_r]};
  assign out_tuser  = ob_has_r;
  assign out_tlast  = (ob_cnt_r == 3'd1);

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the huffman code bit packer: loads code table
// entries, streams encode, flush and unused-mode words with random gaps and
// output stalls, and compares every packed byte and flush word against a
// local bit-packing predictor
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam mode_t ModeIgnored = 2'd3;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned RandomItems = 270;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic [2:0] pad;
    logic       last;
  } pack_res_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [1:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  // predictor state
  logic [WordW-1:0] tab_word [TableDepth];
  logic [LenW-1:0]  tab_len [TableDepth];
  logic [7:0]       pend_byte = '0;
  logic [2:0]       pend_cnt = '0;
  pack_res_t        pack_exp_q [$];

  // stimulus bookkeeping
  bit               sym_loaded [TableDepth];
  logic [7:0]       loaded_syms [$];
  bit               src_fast = 1'b0;
  bit               sink_fast = 1'b0;
  int unsigned      stall_left = 0;
  int unsigned      n_sent = 0;

  int unsigned      cycles = 0;
  int unsigned      err_count = 0;
  int unsigned      n_results = 0;
  int unsigned      n_load = 0;
  int unsigned      n_encode = 0;
  int unsigned      n_flush = 0;
  int unsigned      n_ignored = 0;

  huffman_code_bit_packer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 10);
    else return $urandom_range(15, 40);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    else if (r < 93) return $urandom_range(3, 8);
    else return $urandom_range(15, 40);
  endfunction

  function automatic logic [5:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 6'd0;
    else if (r < 70) return 6'($urandom_range(1, 12));
    else if (r < 85) return 6'($urandom_range(13, 32));
    else return 6'($urandom_range(33, 63));
  endfunction

  // output back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!sink_fast && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left <= pick_stall() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               pack_exp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    if (err_count < MaxReported) $display("[%0t] %s", $realtime, msg);
    err_count++;
  endtask

  // predictor and result checker, both on accepted words at the rising edge
  always @(posedge clk) begin : pack_monitor
    logic [7:0]  sym;
    int unsigned len, total, nb;
    logic [63:0] acc;
    pack_res_t   want, got;

    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sym = in_tdata[7:0];
        case (in_tuser)
          ModeLoad: begin
            len = in_tdata[45:40];
            tab_word[sym] = in_tdata[39:8];
            tab_len[sym] = (len > MaxLen) ? LenW'(MaxLen) : LenW'(len);
            n_load++;
          end
          ModeEncode: begin
            len = tab_len[sym];
            acc = 64'(pend_byte) >> (8 - pend_cnt);
            acc = (acc << len) | (64'(tab_word[sym]) & ((64'd1 << len) - 1));
            total = pend_cnt + len;
            nb = total / 8;
            for (int i = 0; i < nb; i++) begin
              want.data = 8'(acc >> (total - 8 * (i + 1)));
              want.has = 1'b1;
              want.pad = 3'd0;
              want.last = (i == nb - 1);
              pack_exp_q.push_back(want);
            end
            total = total % 8;
            acc &= (64'd1 << total) - 1;
            pend_byte = 8'(acc << (8 - total));
            pend_cnt = 3'(total);
            n_encode++;
          end
          ModeFlush: begin
            want.data = (pend_cnt != 0) ? pend_byte : 8'd0;
            want.has = (pend_cnt != 0);
            want.pad = (pend_cnt != 0) ? 3'(8 - pend_cnt) : 3'd0;
            want.last = 1'b1;
            pack_exp_q.push_back(want);
            pend_byte = '0;
            pend_cnt = '0;
            n_flush++;
          end
          default: begin
            n_ignored++;
          end
        endcase
      end

      if (out_tvalid && out_tready) begin
        got.data = out_tdata[7:0];
        got.pad = out_tdata[10:8];
        got.has = out_tuser;
        got.last = out_tlast;
        n_results++;
        if (pack_exp_q.size() == 0) begin
          note_error($sformatf("unexpected word byte=%h has=%b pad=%0d last=%b",
                               got.data, got.has, got.pad, got.last));
        end else begin
          want = pack_exp_q.pop_front();
          if (got !== want)
            note_error($sformatf({"mismatch exp byte=%h has=%b pad=%0d last=%b",
                                  " got byte=%h has=%b pad=%0d last=%b"},
                                 want.data, want.has, want.pad, want.last,
                                 got.data, got.has, got.pad, got.last));
        end
      end
    end
  end

  // called just after a falling edge, returns just after the falling edge
  // that follows acceptance with in_tvalid still high
  task automatic send_word(input mode_t mode, input logic [7:0] sym,
                           input logic [31:0] word, input logic [5:0] len);
    int unsigned gap;
    gap = src_fast ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, len, word, sym};
    in_tuser <= mode;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (mode == ModeLoad && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    if (mode != ModeIgnored) n_sent++;
  endtask

  task automatic encode_any();
    send_word(ModeEncode, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
              $urandom, 6'($urandom));
  endtask

  task automatic wait_all_out();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pack_exp_q.size() != 0);
  endtask

  task automatic test_directed();
    send_word(ModeFlush, 8'h00, 32'h0, 6'd0);
    send_word(ModeLoad, 8'h00, 32'hFFFF_FFFF, 6'd0);
    send_word(ModeLoad, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_word(ModeLoad, 8'h80, 32'hA5A5_5A5A, 6'd63);
    send_word(ModeLoad, 8'h01, 32'hDEAD_BEEF, 6'd1);
    send_word(ModeLoad, 8'h02, 32'h0000_0055, 6'd7);
    send_word(ModeLoad, 8'h03, 32'h1234_56C3, 6'd8);
    send_word(ModeLoad, 8'h7F, 32'h8000_0001, 6'd33);
    send_word(ModeEncode, 8'h00, 32'h0, 6'd0);
    send_word(ModeEncode, 8'h01, 32'h0, 6'd0);
    send_word(ModeEncode, 8'h02, 32'h0, 6'd0);
    send_word(ModeEncode, 8'h03, 32'h0, 6'd0);
    send_word(ModeEncode, 8'hFF, 32'h0, 6'd0);
    send_word(ModeEncode, 8'h01, 32'h0, 6'd0);
    send_word(ModeEncode, 8'h80, 32'h0, 6'd0);
    send_word(ModeEncode, 8'h7F, 32'h0, 6'd0);
    send_word(ModeIgnored, 8'hAA, 32'h5A5A_A5A5, 6'd63);
    send_word(ModeFlush, 8'h00, 32'h0, 6'd0);
    send_word(ModeFlush, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_word(ModeEncode, 8'h02, 32'h0, 6'd0);
    send_word(ModeFlush, 8'h00, 32'h0, 6'd0);
  endtask

  task automatic test_random_stream();
    int unsigned target, nloads, nwords, r;
    target = n_sent + RandomItems;
    while (n_sent < target) begin
      src_fast = ($urandom_range(0, 99) < 20);
      sink_fast = ($urandom_range(0, 99) < 20);
      nloads = (loaded_syms.size() < 12) ? 6 : $urandom_range(0, 3);
      repeat (nloads) send_word(ModeLoad, 8'($urandom), $urandom, pick_len());
      nwords = $urandom_range(4, 24);
      repeat (nwords) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_word(ModeIgnored, 8'($urandom), $urandom, 6'($urandom));
        else if (r < 6) send_word(ModeFlush, 8'($urandom), $urandom, 6'($urandom));
        else encode_any();
      end
      if ($urandom_range(0, 99) < 80)
        send_word(ModeFlush, 8'($urandom), $urandom, 6'($urandom));
    end
    src_fast = 1'b0;
    sink_fast = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_all_out();
    src_fast = 1'b1;
    sink_fast = 1'b1;
    repeat (16) encode_any();
    src_fast = 1'b0;
    sink_fast = 1'b0;
    repeat (16) encode_any();
    wait_all_out();
    send_word(ModeLoad, loaded_syms[0], $urandom, 6'd32);
    repeat (4) encode_any();
    send_word(ModeFlush, 8'h00, 32'h0, 6'd0);
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      tab_word[i] = '0;
      tab_len[i] = '0;
      sym_loaded[i] = 1'b0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_stream();
    test_drain_pause();

    wait_all_out();
    repeat (DrainCycles) @(negedge clk);
    $display("sent %0d loads, %0d encodes, %0d flushes and %0d unused-mode words",
             n_load, n_encode, n_flush, n_ignored);
    $display("checked %0d output words, %0d mismatches", n_results, err_count);
    if (err_count == 0 && pack_exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
